>>> sv/sector_archive_table_parser_top_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef SECTOR_ARCHIVE_TABLE_PARSER_TOP_MACROS_SVH
`define SECTOR_ARCHIVE_TABLE_PARSER_TOP_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define SATP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every clock edge outside of reset.
`define SATP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequence due in the cycle after the antecedent.
`define SATP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/satp_pkg.sv
package satp_pkg;

  localparam int unsigned SECTOR_BYTES = 2048;
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned ENTRY_BYTES  = 8;
  localparam int unsigned MAX_ENTRIES  = (SECTOR_BYTES - HEADER_BYTES) / ENTRY_BYTES;
  localparam int unsigned POS_W        = $clog2(SECTOR_BYTES);
  localparam int unsigned OFF_W        = 41;
  localparam int unsigned OUT_DEPTH    = 4;
  localparam int unsigned PTR_W        = $clog2(OUT_DEPTH);

  typedef enum logic [2:0] {
    KIND_CHUNK           = 3'd0,
    KIND_ACCEPTED        = 3'd1,
    KIND_TOO_SMALL       = 3'd2,
    KIND_SIZE_MISMATCH   = 3'd3,
    KIND_BAD_COUNT       = 3'd4,
    KIND_CHUNK_OVERRUN   = 3'd5,
    KIND_LAYOUT_MISMATCH = 3'd6
  } satp_kind_e;

  typedef struct packed {
    satp_kind_e  kind;
    logic [7:0]  index;
    logic [31:0] ctype;
    logic [39:0] offset;
    logic [31:0] size;
    logic        last;
  } satp_result_t;

  function automatic satp_result_t satp_verdict(satp_kind_e kind, logic [39:0] offset);
    satp_result_t r;
    r        = '0;
    r.kind   = kind;
    r.offset = offset;
    r.last   = 1'b1;
    return r;
  endfunction

endpackage

>>> sv/satp_parse.sv
module satp_parse import satp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [7:0]         data_byte_i,
  input  logic               first_i,
  input  logic [31:0]        csize_i,
  output satp_result_t [1:0] res_o,
  output logic [1:0]         res_cnt_o
);

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [23:0]      word;
    logic [7:0]       count;
    logic             count_ok;
    logic [31:0]      etype;
    logic [7:0]       num;
    logic [OFF_W-1:0] off;
    logic [31:0]      total;
    logic             done;
  } satp_state_t;

  localparam satp_state_t ST_START = '{
    pos: '0, word: '0, count: '0, count_ok: 1'b0, etype: '0, num: '0,
    off: OFF_W'(SECTOR_BYTES), total: '0, done: 1'b0};
  localparam satp_state_t ST_RESET = '{
    pos: '0, word: '0, count: '0, count_ok: 1'b0, etype: '0, num: '0,
    off: OFF_W'(SECTOR_BYTES), total: '0, done: 1'b1};
  localparam logic [32:0] RND_MASK = 33'(SECTOR_BYTES - 1);

  satp_state_t st_q, st_d;
  satp_state_t cur, nxt;
  logic [31:0]      word_full;
  logic [OFF_W:0]   end_sum;
  logic [32:0]      rnd;
  logic [8:0]       num_inc;

  always_comb begin
    cur       = st_q;
    res_o     = '0;
    res_cnt_o = 2'd0;
    if (first_i) begin
      cur       = ST_START;
      cur.total = csize_i;
      if (csize_i < 32'(SECTOR_BYTES)) begin
        cur.done  = 1'b1;
        res_o[0]  = satp_verdict(KIND_TOO_SMALL, '0);
        res_cnt_o = 2'd1;
      end
    end
    nxt = cur;

    unique case (cur.pos[1:0])
      2'd0: word_full = {24'd0, data_byte_i};
      2'd1: word_full = {16'd0, data_byte_i, cur.word[7:0]};
      2'd2: word_full = {8'd0, data_byte_i, cur.word[15:0]};
      2'd3: word_full = {data_byte_i, cur.word[23:0]};
      default: word_full = '0;
    endcase

    end_sum = {1'b0, cur.off} + (OFF_W + 1)'(word_full);
    rnd     = ({1'b0, word_full} + RND_MASK) & ~RND_MASK;
    num_inc = {1'b0, cur.num} + 9'd1;

    if (!cur.done) begin
      nxt.pos  = cur.pos + POS_W'(1);
      nxt.word = word_full[23:0];
      if (cur.pos == POS_W'(3)) begin
        nxt.count    = word_full[7:0];
        nxt.count_ok = (word_full != 32'd0) && (word_full <= 32'(MAX_ENTRIES));
      end else if (cur.pos == POS_W'(7)) begin
        if (word_full != cur.total) begin
          nxt.done  = 1'b1;
          res_o[0]  = satp_verdict(KIND_SIZE_MISMATCH, '0);
          res_cnt_o = 2'd1;
        end else if (!cur.count_ok) begin
          nxt.done  = 1'b1;
          res_o[0]  = satp_verdict(KIND_BAD_COUNT, '0);
          res_cnt_o = 2'd1;
        end
      end else if (|cur.pos[POS_W-1:3]) begin
        if (cur.pos[2:0] == 3'd3) begin
          nxt.etype = word_full;
        end else if (cur.pos[2:0] == 3'd7) begin
          res_o[0].index  = cur.num;
          res_o[0].ctype  = cur.etype;
          res_o[0].offset = cur.off[39:0];
          res_o[0].size   = word_full;
          res_cnt_o       = 2'd1;
          if (end_sum > (OFF_W + 1)'(cur.total)) begin
            nxt.done       = 1'b1;
            res_o[0].kind  = KIND_CHUNK_OVERRUN;
            res_o[0].last  = 1'b1;
          end else begin
            res_o[0].kind = KIND_CHUNK;
            nxt.off       = cur.off + OFF_W'(rnd);
            nxt.num       = num_inc[7:0];
            if (num_inc >= {1'b0, cur.count}) begin
              nxt.done  = 1'b1;
              res_o[1]  = satp_verdict((nxt.off == OFF_W'(cur.total)) ? KIND_ACCEPTED
                                       : KIND_LAYOUT_MISMATCH, nxt.off[39:0]);
              res_cnt_o = 2'd2;
            end
          end
        end
      end
    end

    if (!fire_i) begin
      res_cnt_o = 2'd0;
    end
    st_d = fire_i ? nxt : st_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_RESET;
    end else begin
      st_q <= st_d;
    end
  end

  `include "sector_archive_table_parser_top_macros.svh"

  `SATP_ASSERT_NEXT(a_last_ends_run, (res_cnt_o != 2'd0) && res_o[res_cnt_o[1]].last, st_q.done, "archive still open after final result")
  `SATP_ASSERT_IMP(a_open_big_enough, !st_q.done, st_q.total >= 32'(SECTOR_BYTES), "open archive smaller than a sector")
  `SATP_ASSERT_IMP(a_num_below_count, !st_q.done && (|st_q.pos[POS_W-1:3]), st_q.num < st_q.count, "entry number past entry count")

endmodule

>>> sv/satp_outq.sv
module satp_outq import satp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  satp_result_t [1:0] push_i,
  input  logic [1:0]         push_cnt_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output satp_result_t       head_o
);

  satp_result_t [OUT_DEPTH-1:0] mem_q;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic             pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign head_o      = mem_q[rd_ptr_q];
  assign room_o      = cnt_q <= (PTR_W + 1)'(OUT_DEPTH - 2);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    cnt_d    = cnt_q + (PTR_W + 1)'(push_cnt_i) - (PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i[0];
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= push_i[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `include "sector_archive_table_parser_top_macros.svh"

  `SATP_ASSERT(a_cnt_bound, cnt_q <= (PTR_W + 1)'(OUT_DEPTH), "result queue over depth")
  `SATP_ASSERT_IMP(a_push_room, push_cnt_i != 2'd0, room_o, "push into full result queue")
  `SATP_ASSERT(a_push_cnt_legal, push_cnt_i != 2'd3, "more than two results per transaction")

endmodule

>>> sv/sector_archive_table_parser_top.sv
// Archive header parser. One header byte is taken per cycle as a valid/ready
// transaction while in_ready_o is high, with first_of_archive_i marking the first
// byte of a new archive (container_size_i is sampled there). The byte is held in
// an input register and parsed once the result queue has room; its results (none,
// one, or a chunk followed by the verdict) enter a four-entry result queue and
// are presented one per cycle while out_ready_i is high, after the input register
// and the queue. Input is taken every cycle while the queue holds two results or
// fewer; a byte that yields two results takes two queue entries. Chunk results
// come before the verdict, so a consumer drops them if the run ends in an error.
module sector_archive_table_parser_top import satp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_of_archive_i,
  input  logic [31:0] container_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [7:0]  chunk_index_o,
  output logic [31:0] chunk_type_o,
  output logic [39:0] chunk_offset_o,
  output logic [31:0] chunk_size_o,
  output logic        last_of_run_o
);

  logic        in_vld_q, in_vld_d;
  logic [7:0]  byte_q;
  logic        first_q;
  logic [31:0] csize_q;
  logic        room;
  logic        fire;
  logic        load;

  satp_result_t [1:0] res;
  logic [1:0]         res_cnt;
  satp_result_t       head;

  assign fire       = in_vld_q && room;
  assign in_ready_o = !in_vld_q || room;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (load) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= data_byte_i;
      first_q <= first_of_archive_i;
      csize_q <= container_size_i;
    end
  end

  satp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .data_byte_i (byte_q),
    .first_i     (first_q),
    .csize_i     (csize_q),
    .res_o       (res),
    .res_cnt_o   (res_cnt)
  );

  satp_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res),
    .push_cnt_i  (res_cnt),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign result_kind_o  = head.kind;
  assign chunk_index_o  = head.index;
  assign chunk_type_o   = head.ctype;
  assign chunk_offset_o = head.offset;
  assign chunk_size_o   = head.size;
  assign last_of_run_o  = head.last;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench import satp_pkg::*;;

  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_BYTES = 480;

  typedef struct {
    logic [7:0]  data;
    logic        first;
    logic [31:0] csize;
  } hdr_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte = '0;
  logic        first_flag = 1'b0;
  logic [31:0] csize = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [2:0]  result_kind_o;
  logic [7:0]  chunk_index_o;
  logic [31:0] chunk_type_o;
  logic [39:0] chunk_offset_o;
  logic [31:0] chunk_size_o;
  logic        last_of_run_o;

  hdr_byte_t    pending_bytes_q[$];
  satp_result_t expected_results_q[$];
  int           total_bytes = 1;
  int           accepted_cnt = 0;
  int           err_cnt = 0;
  int           hold_cnt = 0;
  logic         pressure_done = 1'b0;
  logic         slot_free;
  hdr_byte_t    nxt;
  satp_result_t want;

  // parser model state
  logic [POS_W-1:0] pr_pos = '0;
  logic [31:0]      pr_word = '0;
  logic [31:0]      pr_count = '0;
  logic [31:0]      pr_type = '0;
  logic [7:0]       pr_entry = '0;
  logic [OFF_W-1:0] pr_offset = OFF_W'(SECTOR_BYTES);
  logic [31:0]      pr_total = '0;
  logic             pr_done = 1'b1;

  logic [31:0] ent_type [0:255];
  logic [31:0] ent_size [0:255];

  sector_archive_table_parser_top DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte),
    .first_of_archive_i (first_flag),
    .container_size_i   (csize),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .result_kind_o      (result_kind_o),
    .chunk_index_o      (chunk_index_o),
    .chunk_type_o       (chunk_type_o),
    .chunk_offset_o     (chunk_offset_o),
    .chunk_size_o       (chunk_size_o),
    .last_of_run_o      (last_of_run_o)
  );

  function automatic logic [OFF_W-1:0] sector_round(logic [31:0] sz);
    return ((OFF_W'(sz) + SECTOR_BYTES - 1) / SECTOR_BYTES) * SECTOR_BYTES;
  endfunction

  function automatic void push_result(satp_kind_e kind, logic [7:0] idx, logic [31:0] ctype,
                                      logic [OFF_W-1:0] off, logic [31:0] sz, logic last);
    satp_result_t r;
    r.kind   = kind;
    r.index  = idx;
    r.ctype  = ctype;
    r.offset = off[39:0];
    r.size   = sz;
    r.last   = last;
    expected_results_q.insert(expected_results_q.size(), r);
  endfunction

  task automatic parse_header_byte(input logic [7:0] b, input logic first,
                                   input logic [31:0] size_in);
    logic [POS_W-1:0] p;
    if (first) begin
      pr_pos    = '0;
      pr_word   = '0;
      pr_count  = '0;
      pr_type   = '0;
      pr_entry  = '0;
      pr_offset = OFF_W'(SECTOR_BYTES);
      pr_total  = size_in;
      pr_done   = 1'b0;
      if (size_in < SECTOR_BYTES) begin
        pr_done = 1'b1;
        push_result(KIND_TOO_SMALL, '0, '0, '0, '0, 1'b1);
        return;
      end
    end
    if (pr_done) return;
    p      = pr_pos;
    pr_pos = p + 1'b1;
    if (p[1:0] == 2'd0) pr_word = 32'(b);
    else pr_word = pr_word | (32'(b) << (8 * p[1:0]));

    if (p == 3) begin
      pr_count = pr_word;
    end else if (p == 7) begin
      if (pr_word != pr_total) begin
        pr_done = 1'b1;
        push_result(KIND_SIZE_MISMATCH, '0, '0, '0, '0, 1'b1);
      end else if (pr_count == 0 || pr_count > MAX_ENTRIES) begin
        pr_done = 1'b1;
        push_result(KIND_BAD_COUNT, '0, '0, '0, '0, 1'b1);
      end
    end else if (p >= HEADER_BYTES) begin
      if (p[2:0] == 3'd3) begin
        pr_type = pr_word;
      end else if (p[2:0] == 3'd7) begin
        if (pr_offset > OFF_W'(pr_total) || OFF_W'(pr_word) > OFF_W'(pr_total) - pr_offset) begin
          pr_done = 1'b1;
          push_result(KIND_CHUNK_OVERRUN, pr_entry, pr_type, pr_offset, pr_word, 1'b1);
        end else begin
          push_result(KIND_CHUNK, pr_entry, pr_type, pr_offset, pr_word, 1'b0);
          pr_offset = pr_offset + sector_round(pr_word);
          pr_entry  = pr_entry + 1'b1;
          if (32'(pr_entry) >= pr_count) begin
            pr_done = 1'b1;
            push_result((pr_offset == OFF_W'(pr_total)) ? KIND_ACCEPTED : KIND_LAYOUT_MISMATCH,
                        '0, '0, pr_offset, '0, 1'b1);
          end
        end
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first, input logic [31:0] sz);
    hdr_byte_t t;
    t.data  = b;
    t.first = first;
    t.csize = sz;
    pending_bytes_q.insert(pending_bytes_q.size(), t);
  endtask

  // header, n_ent (type, size) entries from the entry tables, then tail bytes
  task automatic send_archive(input logic [31:0] cont, input logic [31:0] declared,
                              input logic [31:0] count, input int n_ent, input int tail);
    logic [63:0] hdr;
    hdr = {declared, count};
    send_byte(hdr[7:0], 1'b1, cont);
    for (int i = 1; i < 8; i++) send_byte(hdr[8*i +: 8], 1'b0, $urandom);
    for (int e = 0; e < n_ent; e++) begin
      for (int i = 0; i < 4; i++) send_byte(ent_type[e][8*i +: 8], 1'b0, $urandom);
      for (int i = 0; i < 4; i++) send_byte(ent_size[e][8*i +: 8], 1'b0, $urandom);
    end
    repeat (tail) send_byte(8'($urandom), 1'b0, $urandom);
  endtask

  // random entries whose rounded layout fits in 32 bits; total is the exact end
  task automatic build_layout(input int n, output logic [31:0] total);
    logic [OFF_W-1:0] acc;
    logic [OFF_W-1:0] rnd;
    logic [31:0]      sz;
    acc = OFF_W'(SECTOR_BYTES);
    for (int i = 0; i < n; i++) begin
      ent_type[i] = $urandom;
      case ($urandom_range(0, 4))
        0: sz = '0;
        1: sz = $urandom_range(1, 3 * SECTOR_BYTES);
        2: sz = SECTOR_BYTES * $urandom_range(1, 4);
        3: sz = $urandom;
        default: sz = $urandom_range(1, 20000);
      endcase
      rnd = sector_round(sz);
      if (acc + rnd > OFF_W'(32'hFFFF_FFFF)) begin
        sz  = '0;
        rnd = '0;
      end
      ent_size[i] = sz;
      acc = acc + rnd;
    end
    total = acc[31:0];
  endtask

  function automatic int load_phase();
    if (accepted_cnt * 3 < total_bytes) return 0;
    if (accepted_cnt * 3 < total_bytes * 2) return 1;
    return 2;
  endfunction

  function automatic int tx_idle_pct(int ph);
    return (ph == 0) ? 22 : (ph == 1) ? 88 : 0;
  endfunction

  function automatic int rx_idle_pct(int ph);
    return (ph == 0) ? 88 : (ph == 1) ? 22 : 0;
  endfunction

  task automatic cmp_field(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      data_byte  <= '0;
      first_flag <= 1'b0;
      csize      <= '0;
    end else begin
      slot_free = !in_valid || in_ready_o;
      if (in_valid && in_ready_o) begin
        parse_header_byte(data_byte, first_flag, csize);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (slot_free) begin
        if (pending_bytes_q.size() != 0 &&
            $urandom_range(0, 99) >= tx_idle_pct(load_phase())) begin
          nxt = pending_bytes_q.pop_front();
          data_byte  <= nxt.data;
          first_flag <= nxt.first;
          csize      <= nxt.csize;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready     <= 1'b0;
      hold_cnt      <= 0;
      pressure_done <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_results_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual kind %0d offset %0h",
                   $time, result_kind_o, chunk_offset_o);
          err_cnt++;
        end else begin
          want = expected_results_q.pop_front();
          cmp_field("result_kind", want.kind, result_kind_o);
          cmp_field("chunk_index", want.index, chunk_index_o);
          cmp_field("chunk_type", want.ctype, chunk_type_o);
          cmp_field("chunk_offset", want.offset, chunk_offset_o);
          cmp_field("chunk_size", want.size, chunk_size_o);
          cmp_field("last_of_run", want.last, last_of_run_o);
        end
      end
      if (hold_cnt != 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else if (!pressure_done && load_phase() == 2) begin
        hold_cnt      <= HOLD_CYCLES;
        pressure_done <= 1'b1;
        out_ready     <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct(load_phase()));
      end
    end
  end

  initial begin
    logic [31:0]      total;
    logic [31:0]      cnt;
    int               n;
    int               mode;
    int               base;

    // directed
    repeat (3) send_byte(8'($urandom), 1'b0, $urandom);
    send_archive(32'd0, 32'd0, 32'd1, 0, 2);
    send_archive(SECTOR_BYTES - 1, SECTOR_BYTES - 1, 32'd1, 1, 0);
    ent_type[0] = 32'hFFFF_FFFF;
    ent_size[0] = 32'd0;
    send_archive(SECTOR_BYTES, SECTOR_BYTES, 32'd1, 1, 4);
    ent_type[0] = $urandom;
    ent_size[0] = 32'hFFFF_FFFF;
    send_archive(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1, 0);
    ent_size[0] = 32'hFFFF_F7FF;
    send_archive(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1, 0);
    ent_type[1] = $urandom;
    ent_size[0] = SECTOR_BYTES;
    ent_size[1] = SECTOR_BYTES + 1;
    send_archive(SECTOR_BYTES * 4, SECTOR_BYTES * 4, 32'd2, 2, 0);
    send_archive(SECTOR_BYTES * 4 + 1, SECTOR_BYTES * 4 + 1, 32'd2, 2, 0);
    send_archive(SECTOR_BYTES * 4, SECTOR_BYTES * 4 + 1, 32'd2, 2, 0);
    send_archive(SECTOR_BYTES * 4, SECTOR_BYTES * 4, 32'd0, 2, 0);
    send_archive(SECTOR_BYTES * 4, SECTOR_BYTES * 4, MAX_ENTRIES + 1, 2, 0);
    send_archive(SECTOR_BYTES * 4, SECTOR_BYTES * 4, 32'hFFFF_FFFF, 2, 0);
    ent_size[1] = SECTOR_BYTES * 3;
    send_archive(SECTOR_BYTES * 4, SECTOR_BYTES * 4, 32'd2, 2, 0);
    // restart in the middle of an archive
    build_layout(3, total);
    send_archive(total, total, 32'd3, 1, 0);
    build_layout(2, total);
    send_archive(total, total, 32'd2, 2, 1);
    // largest legal count, restarted before the table ends
    build_layout(4, total);
    send_archive(total, total, MAX_ENTRIES, 4, 3);

    // random
    base = pending_bytes_q.size();
    while (pending_bytes_q.size() - base < RANDOM_BYTES) begin
      mode = $urandom_range(0, 99);
      n = $urandom_range(1, 6);
      build_layout(n, total);
      if (mode < 55) begin
        send_archive(total, total, n, n, $urandom_range(0, 3));
      end else if (mode < 63) begin
        if ($urandom_range(0, 1) == 1 && total > 2 * SECTOR_BYTES)
          total = total - $urandom_range(1, total - 2 * SECTOR_BYTES);
        else if (total < 32'hFFFF_0000)
          total = total + $urandom_range(1, 2 * SECTOR_BYTES);
        send_archive(total, total, n, n, 0);
      end else if (mode < 68) begin
        send_archive(total, total ^ (32'd1 << $urandom_range(0, 31)), n, n, 0);
      end else if (mode < 73) begin
        case ($urandom_range(0, 2))
          0: cnt = 32'd0;
          1: cnt = MAX_ENTRIES + 1;
          default: cnt = $urandom;
        endcase
        send_archive(total, total, cnt, n, 0);
      end else if (mode < 78) begin
        send_archive($urandom_range(0, SECTOR_BYTES - 1), $urandom, n, n, 0);
      end else if (mode < 85) begin
        send_archive(total, total, n, $urandom_range(0, n - 1), 0);
      end else if (mode < 92) begin
        repeat ($urandom_range(1, 8))
          send_byte(8'($urandom), ($urandom_range(0, 7) == 0), $urandom);
      end else begin
        total = $urandom;
        for (int k = 0; k < n; k++) ent_size[k] = $urandom;
        send_archive(total, total, n, n, 0);
      end
    end
    total_bytes = pending_bytes_q.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_bytes_q.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_results_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/satp_pkg.sv
sv/satp_parse.sv
sv/satp_outq.sv
sv/sector_archive_table_parser_top.sv
tb/testbench.sv
